>>> rtl/core/arxks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX keystream cipher package
// Widths, constants, types and helper functions shared by the cipher core
// and its channel interfaces.
// ----------------------------------------------------------------------------
package arxks_pkg;

  localparam int WORD_W        = 32;
  localparam int NUM_WORDS     = 16;
  localparam int ROW_W         = 4;
  localparam int WIDX_W        = $clog2(NUM_WORDS);
  localparam int DOUBLE_ROUNDS = 10;
  localparam int DR_W          = $clog2(DOUBLE_ROUNDS + 1);
  localparam int BLOCK_BYTES   = 64;
  localparam int POS_W         = $clog2(BLOCK_BYTES);
  localparam int DATA_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int NUM_CFG_REGS  = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int STEPS_PER_QR  = 4;
  localparam int STEP_W        = $clog2(STEPS_PER_QR * ROW_W);

  localparam int IDX_A = 0;
  localparam int IDX_B = ROW_W;
  localparam int IDX_C = 2 * ROW_W;
  localparam int IDX_D = 3 * ROW_W;

  localparam int ROT_0 = 16;
  localparam int ROT_1 = 12;
  localparam int ROT_2 = 8;
  localparam int ROT_3 = 7;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;
  typedef logic [NUM_CFG_REGS-1:0][CFG_DATA_W-1:0] key_bank_t;

  function automatic word_t bswap32(word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic word_t rotl_step(word_t v, logic [1:0] sel);
    word_t r;
    case (sel)
      2'd0: r = {v[WORD_W-ROT_0-1:0], v[WORD_W-1:WORD_W-ROT_0]};
      2'd1: r = {v[WORD_W-ROT_1-1:0], v[WORD_W-1:WORD_W-ROT_1]};
      2'd2: r = {v[WORD_W-ROT_2-1:0], v[WORD_W-1:WORD_W-ROT_2]};
      default: r = {v[WORD_W-ROT_3-1:0], v[WORD_W-1:WORD_W-ROT_3]};
    endcase
    return r;
  endfunction

  // Rotates row r of the 4x4 word matrix left by (base + r * mult) mod ROW_W.
  function automatic block_t shift_rows(block_t b, int base, int mult);
    block_t o;
    for (int r = 0; r < ROW_W; r++) begin
      for (int j = 0; j < ROW_W; j++) begin
        o[r*ROW_W + j] = b[r*ROW_W + ((j + base + r*mult) % ROW_W)];
      end
    end
    return o;
  endfunction

  function automatic block_t load_block(key_bank_t k);
    block_t b;
    b = '0;
    for (int i = 0; i < NUM_CFG_REGS; i++) begin
      b[2*i]     = k[i][WORD_W-1:0];
      b[2*i + 1] = k[i][CFG_DATA_W-1:WORD_W];
    end
    return b;
  endfunction

endpackage

>>> rtl/core/arxks_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX keystream cipher channel interfaces
// Ready/valid channels for data bytes in, result bytes out and register writes.
// ----------------------------------------------------------------------------
interface arxks_in_if import arxks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_in;
  logic              last_of_message;

  modport source (output valid, data_in, last_of_message, input ready);
  modport sink (input valid, data_in, last_of_message, output ready);
endinterface

interface arxks_out_if import arxks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              end_of_message;

  modport source (output valid, data_out, end_of_message, input ready);
  modport sink (input valid, data_out, end_of_message, output ready);
endinterface

interface arxks_cfg_if import arxks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/arx_keystream_stream_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX keystream stream cipher core
// XORs a byte stream with a keystream made by ten ARX double rounds over a
// 64-byte counter block built from the key and nonce registers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch writes the six 64-bit key and nonce registers by index; a write to
//   one restarts the message. Indices beyond them are accepted and ignored.
//   in_ch takes one byte per transfer with a last-of-message flag, and out_ch
//   returns exactly one byte per input byte, in order, with the flag copied.
// Operation:
//   While a keystream block is held, each byte's result is registered on
//   out_ch in the cycle after its transfer. The first byte of a block
//   waits for the permutation: one adder/XOR/rotate unit does one ARX step a
//   cycle, 32 steps plus 2 row shuffles per double round, after which the
//   finish step XORs the counter block in. After byte 63 the counter block is
//   incremented one word a cycle, from word 15 down while the carry runs on.
// Reset:
//   Keys, nonces and the counter block clear to zero and no keystream is held.
// Stalls:
//   A result waits in the output register while out_ch.ready is low; a byte
//   that needs a new keystream block is still taken and processed meanwhile.
// ----------------------------------------------------------------------------
module arx_keystream_stream_cipher_core import arxks_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  arxks_cfg_if.sink   cfg_ch,
  arxks_in_if.sink    in_ch,
  arxks_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ROUND  = 6'b000010,
    S_PERM   = 6'b000100,
    S_FINISH = 6'b001000,
    S_EMIT   = 6'b010000,
    S_BUMP   = 6'b100000
  } state_t;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLOCK_BYTES - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_QR * ROW_W - 1);
  localparam logic [DR_W-1:0]   DR_LAST   = DR_W'(DOUBLE_ROUNDS - 1);
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(NUM_WORDS - 1);

  state_t              state_r, state_nxt;
  key_bank_t           key_r, key_nxt;
  block_t              cb_r, cb_nxt;
  block_t              w_r, w_nxt;
  block_t              ks_r, ks_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                ks_valid_r, ks_valid_nxt;
  logic [STEP_W-1:0]   st_r, st_nxt;
  logic [DR_W-1:0]     dr_r, dr_nxt;
  logic                diag_r, diag_nxt;
  logic [WIDX_W-1:0]   bidx_r, bidx_nxt;
  logic [DATA_W-1:0]   pend_data_r, pend_data_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                in_ready;
  logic                in_fire;
  logic                cfg_fire;
  logic                emit;
  logic [DATA_W-1:0]   emit_data;
  logic                emit_last;
  word_t               ks_word;
  word_t               ks_shift;
  word_t               op_x, op_y, op_z, op_sum, op_mix;
  word_t               bump_word;
  block_t              w_step;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && (!ks_valid_r || out_free);
  assign in_fire  = in_ch.valid && in_ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready           = in_ready;
  assign cfg_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.data_out       = out_data_r;
  assign out_ch.end_of_message = out_last_r;

  assign ks_word  = ks_r[pos_r[POS_W-1:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  // Shared ARX unit: one add, XOR and rotate per cycle on fixed word slots.
  always_comb begin
    op_x   = st_r[0] ? w_r[IDX_C] : w_r[IDX_A];
    op_y   = st_r[0] ? w_r[IDX_D] : w_r[IDX_B];
    op_z   = st_r[0] ? w_r[IDX_B] : w_r[IDX_D];
    op_sum = op_x + op_y;
    op_mix = rotl_step(op_z ^ op_sum, st_r[1:0]);
    w_step = w_r;
    if (st_r[0]) begin
      w_step[IDX_C] = op_sum;
      w_step[IDX_B] = op_mix;
    end else begin
      w_step[IDX_A] = op_sum;
      w_step[IDX_D] = op_mix;
    end
    if (&st_r[1:0]) begin
      w_step = shift_rows(w_step, 1, 0);
    end
  end

  assign bump_word = bswap32(bswap32(cb_r[bidx_r]) + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    cb_nxt        = cb_r;
    w_nxt         = w_r;
    ks_nxt        = ks_r;
    pos_nxt       = pos_r;
    ks_valid_nxt  = ks_valid_r;
    st_nxt        = st_r;
    dr_nxt        = dr_r;
    diag_nxt      = diag_r;
    bidx_nxt      = bidx_r;
    pend_data_nxt = pend_data_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;
    emit_data     = pend_data_r;
    emit_last     = pend_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (ks_valid_r) begin
            emit      = 1'b1;
            emit_data = in_ch.data_in;
            emit_last = in_ch.last_of_message;
          end else begin
            pend_data_nxt = in_ch.data_in;
            pend_last_nxt = in_ch.last_of_message;
            w_nxt         = cb_r;
            st_nxt        = '0;
            dr_nxt        = '0;
            diag_nxt      = 1'b0;
            state_nxt     = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        w_nxt  = w_step;
        st_nxt = st_r + 1'b1;
        if (st_r == STEP_LAST) begin
          state_nxt = S_PERM;
        end
      end
      S_PERM: begin
        state_nxt = S_ROUND;
        if (!diag_r) begin
          w_nxt    = shift_rows(w_r, 0, 1);
          diag_nxt = 1'b1;
        end else begin
          w_nxt    = shift_rows(w_r, 0, ROW_W - 1);
          diag_nxt = 1'b0;
          if (dr_r == DR_LAST) begin
            state_nxt = S_FINISH;
          end else begin
            dr_nxt = dr_r + 1'b1;
          end
        end
      end
      S_FINISH: begin
        ks_nxt       = w_r ^ cb_r;
        ks_valid_nxt = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_BUMP: begin
        cb_nxt[bidx_r] = bump_word;
        if ((bump_word != '0) || (bidx_r == '0)) begin
          state_nxt = S_IDLE;
        end else begin
          bidx_nxt = bidx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data ^ ks_shift[DATA_W-1:0];
      out_last_nxt  = emit_last;
      if (emit_last) begin
        cb_nxt       = load_block(key_r);
        pos_nxt      = '0;
        ks_valid_nxt = 1'b0;
      end else if (pos_r == POS_LAST) begin
        pos_nxt      = '0;
        ks_valid_nxt = 1'b0;
        bidx_nxt     = WIDX_LAST;
        state_nxt    = S_BUMP;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    if (cfg_fire && (cfg_ch.index < CFG_IDX_W'(NUM_CFG_REGS))) begin
      key_nxt[cfg_ch.index] = cfg_ch.data;
      cb_nxt                = load_block(key_nxt);
      pos_nxt               = '0;
      ks_valid_nxt          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      cb_r        <= '0;
      pos_r       <= '0;
      ks_valid_r  <= 1'b0;
      st_r        <= '0;
      dr_r        <= '0;
      diag_r      <= 1'b0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      cb_r        <= cb_nxt;
      pos_r       <= pos_nxt;
      ks_valid_r  <= ks_valid_nxt;
      st_r        <= st_nxt;
      dr_r        <= dr_nxt;
      diag_r      <= diag_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    ks_r        <= ks_nxt;
    pend_data_r <= pend_data_nxt;
    pend_last_r <= pend_last_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (pos_r == '0 && !ks_valid_r))
    else $error("Message end did not restart the keystream position.");

  a_finish_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> (ks_valid_r && state_r == S_EMIT))
    else $error("Keystream not marked valid after the permutation.");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND || state_r == S_PERM || state_r == S_BUMP)
      |-> (!in_ch.ready && !cfg_ch.ready))
    else $error("Channel ready while the shared unit is busy.");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (dr_r <= DR_LAST))
    else $error("Double round count out of range.");

endmodule
